@@ design/dice_sum_tail_probability_defines.svh @@
// Assertion macros for the dice sum tail probability block
`ifndef DICE_SUM_TAIL_PROBABILITY_DEFINES_SVH
`define DICE_SUM_TAIL_PROBABILITY_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define DSTP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// antecedent implies consequent in the next cycle
`define DSTP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ design/dstp_pkg.sv @@
// Shared types and constants for the dice sum tail probability block
`default_nettype none
package dstp_pkg;

  localparam int DSTP_FACES    = 6;
  localparam int DSTP_MAX_DICE = 24;
  localparam int DSTP_SLOTS    = 256;
  localparam int CW            = 63;

  typedef struct packed {
    logic [4:0] dice_count;
    logic [7:0] target_sum;
  } query_t;

  typedef struct packed {
    logic [CW-1:0] numerator;
    logic [CW-1:0] denominator;
    logic          whole_number;
  } result_t;

  typedef struct packed {
    logic          done;
    logic [CW-1:0] count;
    logic [CW-1:0] total;
  } eng_rsp_t;

  typedef struct packed {
    logic          start;
    logic [CW-1:0] dividend;
    logic [CW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic          done;
    logic [CW-1:0] quo;
    logic [CW-1:0] rem;
  } div_rsp_t;

  typedef enum logic [2:0] {
    E_IDLE, E_INIT, E_DIE_CHK, E_DP, E_DRAIN, E_SUM, E_SUM_DRAIN, E_FIN
  } eng_state_t;

  typedef enum logic [2:0] {
    C_IDLE, C_ROW, C_GCD_CHK, C_GCD_WAIT, C_NUM_WAIT, C_DEN_WAIT, C_DONE
  } ctl_state_t;

endpackage
`default_nettype wire

@@ design/dstp_divider.sv @@
// Bit-serial restoring divider giving quotient and remainder
`default_nettype none
module dstp_divider (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire dstp_pkg::div_req_t req,
  output dstp_pkg::div_rsp_t     rsp
);
  import dstp_pkg::*;

  localparam int NW = $clog2(CW + 1);

  logic          busy;
  logic          done;
  logic [NW-1:0] cnt;
  logic [CW-1:0] rem;
  logic [CW-1:0] quo;
  logic [CW-1:0] dvs;
  logic [CW:0]   trial;
  logic          fits;

  assign trial = {rem, quo[CW-1]};
  assign fits  = trial >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (!busy && req.start) begin
        busy <= 1'b1;
        cnt  <= NW'(CW);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == NW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!busy && req.start) begin
      rem <= '0;
      quo <= req.dividend;
      dvs <= req.divisor;
    end else if (busy) begin
      rem <= fits ? CW'(trial - {1'b0, dvs}) : trial[CW-1:0];
      quo <= {quo[CW-2:0], fits};
    end
  end

  assign rsp.done = done;
  assign rsp.quo  = quo;
  assign rsp.rem  = rem;
endmodule
`default_nettype wire

@@ design/dstp_row_engine.sv @@
// Distribution row memory with sliding-window update and tail sum
`default_nettype none
module dstp_row_engine #(
  parameter int FACE_COUNT = dstp_pkg::DSTP_FACES,
  parameter int MAX_DICE   = dstp_pkg::DSTP_MAX_DICE,
  parameter int SUM_SLOTS  = dstp_pkg::DSTP_SLOTS
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            start,
  input  wire dstp_pkg::query_t qry,
  output dstp_pkg::eng_rsp_t   rsp
);
  import dstp_pkg::*;

  localparam int AW = $clog2(SUM_SLOTS);
  localparam logic [AW-1:0] FSTEP = AW'(FACE_COUNT);

  logic [CW-1:0] row_mem [SUM_SLOTS];
  logic [CW-1:0] q;
  logic [AW-1:0] raddr;
  logic [AW-1:0] waddr;
  logic [CW-1:0] wdata;
  logic          we;

  eng_state_t    state, state_next;
  logic [4:0]    n;
  logic [4:0]    d;
  logic [7:0]    tgt;
  logic [AW-1:0] hi;
  logic [AW-1:0] k;
  logic [AW-1:0] sidx;
  logic          p_v;
  logic          p_rd;
  logic          p_sv;
  logic [AW-1:0] p_waddr;
  logic [CW-1:0] win;
  logic [CW-1:0] shl [FACE_COUNT];
  logic [CW-1:0] total;
  logic [CW-1:0] count;
  logic [CW-1:0] in_val;
  logic [CW-1:0] w_new;

  assign in_val = p_rd ? q : '0;
  assign w_new  = win + in_val - shl[FACE_COUNT-1];

  always_comb begin
    state_next = state;
    case (state)
      E_IDLE:      if (start) state_next = E_INIT;
      E_INIT:      state_next = E_DIE_CHK;
      E_DIE_CHK: begin
        if (d != n) state_next = E_DP;
        else if (AW'(tgt) <= hi && {1'b0, tgt} <= 9'(SUM_SLOTS - 1)) state_next = E_SUM;
        else state_next = E_FIN;
      end
      E_DP:        if (k == hi + FSTEP) state_next = E_DRAIN;
      E_DRAIN:     state_next = E_DIE_CHK;
      E_SUM:       if (sidx == hi) state_next = E_SUM_DRAIN;
      E_SUM_DRAIN: state_next = E_FIN;
      E_FIN:       state_next = E_IDLE;
      default:     state_next = E_IDLE;
    endcase
  end

  always_comb begin
    we    = 1'b0;
    waddr = p_waddr;
    wdata = w_new;
    raddr = (state == E_SUM) ? sidx : AW'(hi - k);
    case (state)
      E_INIT: begin
        we    = 1'b1;
        waddr = '0;
        wdata = CW'(1);
      end
      E_DP, E_DRAIN: we = p_v;
      default: we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) row_mem[waddr] <= wdata;
    q <= row_mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= E_IDLE;
      p_v   <= 1'b0;
      p_sv  <= 1'b0;
    end else begin
      state <= state_next;
      p_v   <= (state == E_DP);
      p_sv  <= (state == E_SUM);
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      E_IDLE: begin
        if (start) begin
          n   <= (qry.dice_count > 5'(MAX_DICE)) ? 5'(MAX_DICE) : qry.dice_count;
          tgt <= qry.target_sum;
        end
      end
      E_INIT: begin
        hi    <= '0;
        d     <= '0;
        total <= CW'(1);
      end
      E_DIE_CHK: begin
        k     <= '0;
        win   <= '0;
        count <= '0;
        sidx  <= AW'(tgt);
        for (int i = 0; i < FACE_COUNT; i++) shl[i] <= '0;
      end
      E_DP: begin
        k       <= k + 1'b1;
        p_rd    <= (k <= hi);
        p_waddr <= AW'(hi + FSTEP - k);
      end
      E_DRAIN: begin
        hi    <= hi + FSTEP;
        d     <= d + 1'b1;
        total <= CW'(total * CW'(FACE_COUNT));
      end
      E_SUM: sidx <= sidx + 1'b1;
      default: ;
    endcase
    if (p_v) begin
      win    <= w_new;
      shl[0] <= in_val;
      for (int i = 1; i < FACE_COUNT; i++) shl[i] <= shl[i-1];
    end
    if (p_sv) count <= count + q;
  end

  assign rsp.done  = (state == E_FIN);
  assign rsp.count = count;
  assign rsp.total = total;
endmodule
`default_nettype wire

@@ design/dice_sum_tail_probability.sv @@
// Top level: query intake, Euclid sequencing and result register
//
// One query at a time. A query builds the dice-total distribution in a
// single-port-read row memory, one die per sweep up to hi+FACE_COUNT (hi
// being the largest total so far), then sums the tail and, unless the tail
// count is zero, runs Euclid on a bit-serial divider with 63-bit operands:
// one division per remainder step, plus two divisions for the reduced
// fraction.
// A new query is taken as soon as the previous result sits in the output
// register, even if that result is still stalled.
`default_nettype none
module dice_sum_tail_probability #(
  parameter int FACE_COUNT = dstp_pkg::DSTP_FACES,
  parameter int MAX_DICE   = dstp_pkg::DSTP_MAX_DICE,
  parameter int SUM_SLOTS  = dstp_pkg::DSTP_SLOTS
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             query_valid,
  input  wire dstp_pkg::query_t  query,
  output logic                  query_stall,
  output logic                  result_valid,
  output dstp_pkg::result_t     result,
  input  wire logic             result_stall
);
  import dstp_pkg::*;

  ctl_state_t    state, state_next;
  eng_rsp_t      eng;
  div_req_t      dreq;
  div_rsp_t      drsp;
  logic          eng_start;
  logic          out_free;
  logic [CW-1:0] count;
  logic [CW-1:0] total;
  logic [CW-1:0] ga;
  logic [CW-1:0] gb;
  logic [CW-1:0] num;
  logic [CW-1:0] den;

  dstp_row_engine #(
    .FACE_COUNT (FACE_COUNT),
    .MAX_DICE   (MAX_DICE),
    .SUM_SLOTS  (SUM_SLOTS)
  ) u_row (
    .clk   (clk),
    .rst   (rst),
    .start (eng_start),
    .qry   (query),
    .rsp   (eng)
  );

  dstp_divider u_div (
    .clk (clk),
    .rst (rst),
    .req (dreq),
    .rsp (drsp)
  );

  assign out_free = !result_valid || !result_stall;

  always_comb begin
    state_next = state;
    case (state)
      C_IDLE:     if (query_valid) state_next = C_ROW;
      C_ROW: begin
        if (eng.done) state_next = (eng.count == '0) ? C_DONE : C_GCD_CHK;
      end
      C_GCD_CHK:  state_next = (gb == '0) ? C_NUM_WAIT : C_GCD_WAIT;
      C_GCD_WAIT: if (drsp.done) state_next = C_GCD_CHK;
      C_NUM_WAIT: if (drsp.done) state_next = C_DEN_WAIT;
      C_DEN_WAIT: if (drsp.done) state_next = C_DONE;
      C_DONE:     if (out_free) state_next = C_IDLE;
      default:    state_next = C_IDLE;
    endcase
  end

  always_comb begin
    query_stall   = (state != C_IDLE);
    eng_start     = (state == C_IDLE) && query_valid;
    dreq.start    = 1'b0;
    dreq.dividend = ga;
    dreq.divisor  = gb;
    case (state)
      C_GCD_CHK: begin
        dreq.start = 1'b1;
        if (gb == '0) begin
          dreq.dividend = count;
          dreq.divisor  = ga;
        end
      end
      C_NUM_WAIT: begin
        dreq.start    = drsp.done;
        dreq.dividend = total;
        dreq.divisor  = ga;
      end
      default: dreq.start = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= C_IDLE;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == C_DONE && out_free) result_valid <= 1'b1;
      else if (!result_stall) result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      C_ROW: begin
        if (eng.done) begin
          count <= eng.count;
          total <= eng.total;
          ga    <= eng.total;
          gb    <= eng.count;
          num   <= '0;
          den   <= CW'(1);
        end
      end
      C_GCD_WAIT: begin
        if (drsp.done) begin
          ga <= gb;
          gb <= drsp.rem;
        end
      end
      C_NUM_WAIT: if (drsp.done) num <= drsp.quo;
      C_DEN_WAIT: if (drsp.done) den <= drsp.quo;
      default: ;
    endcase
    if (state == C_DONE && out_free) begin
      result.numerator    <= num;
      result.denominator  <= den;
      result.whole_number <= (den == CW'(1));
    end
  end
endmodule
`default_nettype wire

@@ design/dstp_checker.sv @@
// Port-level checker for the dice sum tail probability block, with bind
`default_nettype none
`include "dice_sum_tail_probability_defines.svh"
module dstp_checker (
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              query_valid,
  input wire logic              query_stall,
  input wire logic              result_valid,
  input wire dstp_pkg::result_t  result,
  input wire logic              result_stall
);
  import dstp_pkg::*;

  `DSTP_ASSERT_NEXT(a_hold, result_valid && result_stall, result_valid && $stable(result), "stalled result changed")
  `DSTP_ASSERT_NOW(a_whole, result_valid, result.whole_number == (result.denominator == CW'(1)), "whole flag wrong")
  `DSTP_ASSERT_NOW(a_order, result_valid, result.numerator <= result.denominator, "fraction above one")
  `DSTP_ASSERT_NEXT(a_busy, query_valid && !query_stall, query_stall, "second transfer while busy")
endmodule

bind dice_sum_tail_probability dstp_checker u_chk (
  .clk          (clk),
  .rst          (rst),
  .query_valid  (query_valid),
  .query_stall  (query_stall),
  .result_valid (result_valid),
  .result       (result),
  .result_stall (result_stall)
);
`default_nettype wire
